// ===== rtl/core/ptw_pkg.sv =====
package ptw_pkg;

  localparam int unsigned VA_W    = 48;
  localparam int unsigned ADDR_W  = 52;
  localparam int unsigned ENTRY_W = 64;
  localparam int unsigned IDX_W   = 9;

  localparam logic OP_START = 1'b0;
  localparam logic OP_ENTRY = 1'b1;

  localparam logic RK_REQ  = 1'b0;
  localparam logic RK_DONE = 1'b1;

  localparam logic [1:0] PS_4K = 2'd0;
  localparam logic [1:0] PS_2M = 2'd1;
  localparam logic [1:0] PS_1G = 2'd2;

  // level whose entry is awaited
  localparam logic [1:0] LVL_PML4 = 2'd0;
  localparam logic [1:0] LVL_PDPT = 2'd1;
  localparam logic [1:0] LVL_PD   = 2'd2;
  localparam logic [1:0] LVL_PT   = 2'd3;

  localparam int unsigned LARGE_BIT = 7;

  typedef enum logic [1:0] {
    KIND_START      = 2'd0,
    KIND_ENTRY_ZERO = 2'd1,
    KIND_ENTRY      = 2'd2
  } item_kind_e;

  typedef struct packed {
    item_kind_e           kind;
    logic [ENTRY_W-1:0]   data;
  } item_t;

endpackage

// ===== rtl/core/ptw_front.sv =====
module ptw_front (
  input  logic                        opcode_i,
  input  logic [ptw_pkg::VA_W-1:0]    virt_addr_i,
  input  logic [ptw_pkg::ENTRY_W-1:0] entry_data_i,
  output ptw_pkg::item_t              item_o
);
  import ptw_pkg::*;

  always_comb begin
    if (opcode_i == OP_START) begin
      item_o.kind = KIND_START;
      item_o.data = {{(ENTRY_W-VA_W){1'b0}}, virt_addr_i};
    end else begin
      item_o.kind = (entry_data_i == '0) ? KIND_ENTRY_ZERO : KIND_ENTRY;
      item_o.data = entry_data_i;
    end
  end

endmodule

// ===== rtl/core/ptw_queue.sv =====
module ptw_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  ptw_pkg::item_t push_item_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output ptw_pkg::item_t pop_item_o
);
  import ptw_pkg::*;

  item_t      mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       push, pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop_item_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      case ({push, pop})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

// ===== rtl/core/ptw_back.sv =====
module ptw_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [ptw_pkg::ADDR_W-1:0] cfg_data_i,
  input  logic                       item_valid_i,
  output logic                       item_ready_o,
  input  ptw_pkg::item_t             item_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic                       result_kind_o,
  output logic [ptw_pkg::ADDR_W-1:0] address_o,
  output logic                       fault_o,
  output logic [1:0]                 page_size_o
);
  import ptw_pkg::*;

  logic [ADDR_W-1:0] root_q;
  logic              busy_q, busy_d;
  logic [1:0]        level_q, level_d;
  logic [VA_W-1:0]   va_q, va_d;

  logic              out_valid_q;
  logic              kind_q, kind_d;
  logic [ADDR_W-1:0] addr_q, addr_d;
  logic              fault_q, fault_d;
  logic [1:0]        size_q, size_d;

  logic              pop, res_valid;
  logic [ADDR_W-1:0] table_base;
  logic [IDX_W-1:0]  next_idx;
  logic [ADDR_W-1:0] next_req;
  logic [ADDR_W-1:0] gb_addr, mb_addr, kb_addr, root_req;
  logic [VA_W-1:0]   start_va;

  assign item_ready_o = !out_valid_q || out_ready_i;
  assign pop          = item_valid_i && item_ready_o;

  assign start_va   = item_i.data[VA_W-1:0];
  assign table_base = {item_i.data[ADDR_W-1:12], 12'b0};
  assign root_req   = root_q + {{(ADDR_W-IDX_W-3){1'b0}}, start_va[47:39], 3'b000};
  assign gb_addr    = {item_i.data[ADDR_W-1:30], 30'b0}
                      + {{(ADDR_W-30){1'b0}}, va_q[29:0]};
  assign mb_addr    = {item_i.data[ADDR_W-1:21], 21'b0}
                      + {{(ADDR_W-21){1'b0}}, va_q[20:0]};
  assign kb_addr    = table_base + {{(ADDR_W-12){1'b0}}, va_q[11:0]};

  always_comb begin
    unique case (level_q)
      LVL_PML4: next_idx = va_q[38:30];
      LVL_PDPT: next_idx = va_q[29:21];
      LVL_PD:   next_idx = va_q[20:12];
      default:  next_idx = va_q[20:12];
    endcase
  end

  assign next_req = table_base + {{(ADDR_W-IDX_W-3){1'b0}}, next_idx, 3'b000};

  always_comb begin
    busy_d    = busy_q;
    level_d   = level_q;
    va_d      = va_q;
    res_valid = 1'b0;
    kind_d    = RK_REQ;
    addr_d    = '0;
    fault_d   = 1'b0;
    size_d    = PS_4K;
    if (pop) begin
      unique case (item_i.kind)
        KIND_START: begin
          if (!busy_q) begin
            res_valid = 1'b1;
            if (root_q == '0) begin
              kind_d  = RK_DONE;
              fault_d = 1'b1;
            end else begin
              busy_d  = 1'b1;
              level_d = LVL_PML4;
              va_d    = start_va;
              addr_d  = root_req;
            end
          end
        end
        KIND_ENTRY_ZERO: begin
          if (busy_q) begin
            res_valid = 1'b1;
            kind_d    = RK_DONE;
            fault_d   = 1'b1;
            busy_d    = 1'b0;
            level_d   = LVL_PML4;
          end
        end
        KIND_ENTRY: begin
          if (busy_q) begin
            res_valid = 1'b1;
            unique case (level_q)
              LVL_PML4: begin
                addr_d  = next_req;
                level_d = LVL_PDPT;
              end
              LVL_PDPT: begin
                if (item_i.data[LARGE_BIT]) begin
                  kind_d  = RK_DONE;
                  addr_d  = gb_addr;
                  size_d  = PS_1G;
                  busy_d  = 1'b0;
                  level_d = LVL_PML4;
                end else begin
                  addr_d  = next_req;
                  level_d = LVL_PD;
                end
              end
              LVL_PD: begin
                if (item_i.data[LARGE_BIT]) begin
                  kind_d  = RK_DONE;
                  addr_d  = mb_addr;
                  size_d  = PS_2M;
                  busy_d  = 1'b0;
                  level_d = LVL_PML4;
                end else begin
                  addr_d  = next_req;
                  level_d = LVL_PT;
                end
              end
              default: begin
                kind_d  = RK_DONE;
                addr_d  = kb_addr;
                busy_d  = 1'b0;
                level_d = LVL_PML4;
              end
            endcase
          end
        end
        default: begin
          res_valid = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_q      <= '0;
      busy_q      <= 1'b0;
      level_q     <= LVL_PML4;
      va_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        root_q <= cfg_data_i;
      end
      busy_q  <= busy_d;
      level_q <= level_d;
      va_q    <= va_d;
      if (res_valid) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      kind_q  <= kind_d;
      addr_q  <= addr_d;
      fault_q <= fault_d;
      size_q  <= size_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign result_kind_o = kind_q;
  assign address_o     = addr_q;
  assign fault_o       = fault_q;
  assign page_size_o   = size_q;

`ifndef SYNTHESIS
  a_idle_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> level_q == LVL_PML4)
    else $error("walker idle with nonzero level");

  a_fault_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && fault_q |-> kind_q == RK_DONE && addr_q == '0 && size_q == PS_4K)
    else $error("fault result malformed");

  a_req_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && kind_q == RK_REQ |-> busy_q && size_q == PS_4K && !fault_q)
    else $error("read request while walker idle");

  a_hold_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> $stable(busy_q) && $stable(level_q))
    else $error("walk state moved during output stall");
`endif

endmodule

// ===== rtl/core/four_level_page_table_walker_top.sv =====
// Channel | Handshake                 | Fields
// in      | in_valid_i / in_ready_o   | opcode_i, virt_addr_i, entry_data_i
// out     | out_valid_o / out_ready_i | result_kind_o, address_o, fault_o, page_size_o
// cfg     | cfg_we_i                  | cfg_data_i (table root)
//
// One transaction per cycle sustained while out_ready_i is held high; an accepted input
// goes into a queue entry, then the walk-state update writes its result into the output register.
// A 2-entry queue separates classification from the walk state machine.
// Reset clears the table root, walk state, queue and output valid; no clearing pass.
// An output stall holds the walk state; the queue keeps taking input until full.
module four_level_page_table_walker_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [ptw_pkg::ADDR_W-1:0]  cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        opcode_i,
  input  logic [ptw_pkg::VA_W-1:0]    virt_addr_i,
  input  logic [ptw_pkg::ENTRY_W-1:0] entry_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        result_kind_o,
  output logic [ptw_pkg::ADDR_W-1:0]  address_o,
  output logic                        fault_o,
  output logic [1:0]                  page_size_o
);
  import ptw_pkg::*;

  item_t front_item, queue_item;
  logic  queue_valid, queue_ready;

  ptw_front u_front (
    .opcode_i     (opcode_i),
    .virt_addr_i  (virt_addr_i),
    .entry_data_i (entry_data_i),
    .item_o       (front_item)
  );

  ptw_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (in_valid_i),
    .push_ready_o (in_ready_o),
    .push_item_i  (front_item),
    .pop_valid_o  (queue_valid),
    .pop_ready_i  (queue_ready),
    .pop_item_o   (queue_item)
  );

  ptw_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_data_i    (cfg_data_i),
    .item_valid_i  (queue_valid),
    .item_ready_o  (queue_ready),
    .item_i        (queue_item),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .result_kind_o (result_kind_o),
    .address_o     (address_o),
    .fault_o       (fault_o),
    .page_size_o   (page_size_o)
  );

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import ptw_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 8;
  localparam logic [ADDR_W-1:0] ROOT_MAX = '1;

  typedef struct {
    logic               op;
    logic [VA_W-1:0]    va;
    logic [ENTRY_W-1:0] ent;
  } walk_item_t;

  typedef struct packed {
    logic              kind;
    logic [ADDR_W-1:0] addr;
    logic              fault;
    logic [1:0]        size;
  } walk_res_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [ADDR_W-1:0]   cfg_data_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic                opcode_i = OP_START;
  logic [VA_W-1:0]     virt_addr_i = '0;
  logic [ENTRY_W-1:0]  entry_data_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic                result_kind_o;
  logic [ADDR_W-1:0]   address_o;
  logic                fault_o;
  logic [1:0]          page_size_o;

  walk_item_t walk_items_q[$];
  walk_res_t  walk_results_q[$];

  // shadow of the walker
  logic [ADDR_W-1:0] root_reg = '0;
  logic              pt_active = 1'b0;
  logic [1:0]        pt_depth = LVL_PML4;
  logic [VA_W-1:0]   pt_vaddr = '0;

  bit in_taken = 1'b0;
  bit out_taken = 1'b0;
  int in_gap = 0;
  int in_calm = 0;
  int out_stall = 0;
  int out_calm = 0;
  int idle_cycles = 0;
  int mismatches = 0;
  int items_added = 0;

  four_level_page_table_walker_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .opcode_i      (opcode_i),
    .virt_addr_i   (virt_addr_i),
    .entry_data_i  (entry_data_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .result_kind_o (result_kind_o),
    .address_o     (address_o),
    .fault_o       (fault_o),
    .page_size_o   (page_size_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic bit translate_step(input logic op, input logic [VA_W-1:0] va,
                                        input logic [ENTRY_W-1:0] ent,
                                        output walk_res_t res);
    logic [11:0] idx8;
    res = '{kind: RK_REQ, addr: '0, fault: 1'b0, size: PS_4K};
    if (op == OP_START) begin
      if (pt_active) return 1'b0;
      if (root_reg == '0) begin
        res.kind  = RK_DONE;
        res.fault = 1'b1;
        return 1'b1;
      end
      pt_vaddr  = va;
      pt_active = 1'b1;
      pt_depth  = LVL_PML4;
      res.addr  = root_reg + {40'd0, va[47:39], 3'b000};
      return 1'b1;
    end
    if (!pt_active) return 1'b0;
    if (ent == '0) begin
      pt_active = 1'b0;
      pt_depth  = LVL_PML4;
      res.kind  = RK_DONE;
      res.fault = 1'b1;
      return 1'b1;
    end
    if (pt_depth == LVL_PT || (pt_depth != LVL_PML4 && ent[LARGE_BIT])) begin
      case (pt_depth)
        LVL_PDPT: begin
          res.addr = {ent[51:30], pt_vaddr[29:0]};
          res.size = PS_1G;
        end
        LVL_PD: begin
          res.addr = {ent[51:21], pt_vaddr[20:0]};
          res.size = PS_2M;
        end
        default: begin
          res.addr = {ent[51:12], pt_vaddr[11:0]};
          res.size = PS_4K;
        end
      endcase
      res.kind  = RK_DONE;
      pt_active = 1'b0;
      pt_depth  = LVL_PML4;
      return 1'b1;
    end
    case (pt_depth)
      LVL_PML4: idx8 = {pt_vaddr[38:30], 3'b000};
      LVL_PDPT: idx8 = {pt_vaddr[29:21], 3'b000};
      default:  idx8 = {pt_vaddr[20:12], 3'b000};
    endcase
    res.addr = {ent[51:12], 12'h000} + {40'd0, idx8};
    pt_depth = pt_depth + 2'd1;
    return 1'b1;
  endfunction

  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) calm = $urandom_range(20, 60);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [VA_W-1:0] rand_va();
    case ($urandom_range(0, 9))
      0: return '1;
      1: return '0;
      default: return VA_W'({$urandom(), $urandom()});
    endcase
  endfunction

  function automatic logic [ENTRY_W-1:0] rand_entry();
    logic [ENTRY_W-1:0] e;
    case ($urandom_range(0, 9))
      0: e = '1;
      1: e = 64'd1 << $urandom_range(0, 63);
      default: e = {$urandom(), $urandom()};
    endcase
    if (e == '0) e[12] = 1'b1;
    return e;
  endfunction

  task automatic add_item(input logic op, input logic [VA_W-1:0] va,
                          input logic [ENTRY_W-1:0] ent);
    walk_items_q.push_back('{op: op, va: va, ent: ent});
    items_added++;
  endtask

  // one walk; a truncated walk can stop before its last entry and leave the walker busy
  task automatic add_walk(input bit truncate);
    int end_lvl;
    int flt_lvl;
    int cut_lvl;
    logic [ENTRY_W-1:0] e;
    end_lvl = $urandom_range(1, 3);
    flt_lvl = 4;
    cut_lvl = truncate ? $urandom_range(0, 3) : 4;
    if ($urandom_range(0, 4) == 0) begin
      end_lvl = 3;
      flt_lvl = $urandom_range(0, 3);
    end
    add_item(OP_START, rand_va(), {$urandom(), $urandom()});
    for (int l = 0; l < 4; l++) begin
      if (l == cut_lvl) break;
      if ($urandom_range(0, 19) == 0) add_item(OP_START, rand_va(), rand_entry());
      if (l == flt_lvl) begin
        add_item(OP_ENTRY, rand_va(), '0);
        break;
      end
      e = rand_entry();
      if (l == 1 || l == 2) e[LARGE_BIT] = (l == end_lvl);
      if (e == '0) e[12] = 1'b1;
      add_item(OP_ENTRY, rand_va(), e);
      if (l == end_lvl) break;
    end
  endtask

  task automatic add_random(input int count);
    int r;
    items_added = 0;
    while (items_added < count) begin
      r = $urandom_range(0, 99);
      if (r < 75) add_walk(1'b0);
      else if (r < 85) add_walk(1'b1);
      else add_item(1'($urandom_range(0, 1)), rand_va(),
                    ($urandom_range(0, 3) == 0) ? '0 : rand_entry());
    end
  endtask

  task automatic drain();
    do begin
      @(posedge clk_i);
      #1;
    end while (walk_items_q.size() != 0 || in_valid_i || walk_results_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_root(input logic [ADDR_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    root_reg = value;
    @(posedge clk_i);
    #1;
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatches++;
    if (mismatches <= 100)
      $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
  endtask

  // driver
  always @(negedge clk_i) begin : drive_p
    walk_item_t it;
    if (!(in_valid_i && !in_taken)) begin
      in_taken = 1'b0;
      if (in_gap > 0) begin
        in_gap--;
        in_valid_i <= 1'b0;
      end else if (walk_items_q.size() > 0) begin
        it = walk_items_q.pop_front();
        opcode_i     <= it.op;
        virt_addr_i  <= it.va;
        entry_data_i <= it.ent;
        in_valid_i   <= 1'b1;
        in_gap = pick_gap(in_calm);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // result sink
  always @(negedge clk_i) begin
    if (out_taken) begin
      out_taken = 1'b0;
      out_stall = pick_gap(out_calm);
    end
    if (out_stall > 0) begin
      out_stall--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // monitor
  always @(posedge clk_i) begin : monitor_p
    bit in_fire;
    bit out_fire;
    walk_res_t res;
    walk_res_t want;
    in_fire  = rst_ni && in_valid_i && in_ready_o;
    out_fire = rst_ni && out_valid_o && out_ready_i;
    if (in_fire) begin
      in_taken = 1'b1;
      if (translate_step(opcode_i, virt_addr_i, entry_data_i, res))
        walk_results_q.push_back(res);
    end
    if (out_fire) begin
      out_taken = 1'b1;
      if (walk_results_q.size() == 0) begin
        report_mismatch("unexpected transaction, address", 64'(address_o), '0);
      end else begin
        want = walk_results_q.pop_front();
        if (result_kind_o !== want.kind)
          report_mismatch("result_kind", 64'(result_kind_o), 64'(want.kind));
        if (address_o !== want.addr)
          report_mismatch("address", 64'(address_o), 64'(want.addr));
        if (fault_o !== want.fault)
          report_mismatch("fault", 64'(fault_o), 64'(want.fault));
        if (page_size_o !== want.size)
          report_mismatch("page_size", 64'(page_size_o), 64'(want.size));
      end
    end
    if (in_fire || out_fire) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // all-ones root checks the 52-bit wrap of the first request
    write_root(ROOT_MAX);
    add_item(OP_ENTRY, '1, '1);
    add_item(OP_START, '1, '0);
    add_item(OP_START, '0, '1);
    add_item(OP_ENTRY, '0, '1);
    add_item(OP_ENTRY, '0, 64'h8000_0000_0000_0080);
    add_item(OP_START, '0, '0);
    add_item(OP_ENTRY, '1, 64'h0000_0000_0000_0001);
    add_item(OP_ENTRY, '1, 64'hFFFF_FFFF_FFFF_FF7F);
    add_item(OP_ENTRY, '1, 64'h000F_FFFF_FFE0_0080);
    add_item(OP_START, 48'h8421_0842_1084, '0);
    add_item(OP_ENTRY, '0, rand_entry());
    add_item(OP_ENTRY, '0, 64'h7FFF_FFFF_FFFF_FF7F);
    add_item(OP_ENTRY, '0, 64'h0000_0000_0000_7F00);
    add_item(OP_ENTRY, '0, '1);
    add_item(OP_START, rand_va(), '1);
    add_item(OP_ENTRY, '1, '0);
    add_item(OP_START, '1, '1);
    add_item(OP_ENTRY, '0, 64'h0000_0000_0000_1000);
    add_item(OP_ENTRY, '0, 64'hFFFF_FFFF_FFFF_FF7F);
    add_item(OP_ENTRY, '0, 64'h0000_0000_0000_0100);
    add_item(OP_ENTRY, '1, '0);
    drain();

    write_root(ADDR_W'({$urandom(), $urandom()}) | 52'd1);
    add_random(190);
    drain();

    // zero root: every start taken while the walker is idle faults
    write_root('0);
    add_random(40);
    drain();

    write_root(ADDR_W'({$urandom_range(1, 255), 12'h000}));
    add_random(190);
    drain();

    write_root(ROOT_MAX);
    add_random(190);
    drain();

    write_root(ADDR_W'({$urandom(), $urandom()}) | 52'd1);
    add_random(190);
    drain();

    if (mismatches == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/ptw_pkg.sv
rtl/core/ptw_front.sv
rtl/core/ptw_queue.sv
rtl/core/ptw_back.sv
rtl/core/four_level_page_table_walker_top.sv
test/testbench.sv
